### hw/rtl/jav_pkg.sv
// ----------------------------------------------------------------------------
// jav_pkg
// Shared constants, register codes and pipeline sideband types for the
// joystick to arc velocity unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jav_pkg;

  localparam int unsigned CORDIC_ITERS = 28;
  localparam int unsigned CORDIC_W     = 32;
  localparam longint      HALF_PI_Q30  = 64'sd1686629713;

  localparam logic [CORDIC_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,
    32'd64,        32'd32,        32'd16,        32'd8
  };

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 15;
  localparam int unsigned VEL_W     = 16;
  localparam int unsigned LM_W      = 25;
  localparam int unsigned SC_W      = 30;
  localparam int unsigned GEOM_W    = 12;
  localparam int unsigned NUM_W     = 55;
  localparam int unsigned PRD_W     = 42;
  localparam int unsigned DEN_W     = 43;
  localparam int unsigned N_W       = 56;
  localparam int unsigned D_W       = 44;
  localparam int unsigned Q_W       = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_DB   = 3'd0,
    REG_STEER_DB   = 3'd1,
    REG_MAX_LIN    = 3'd2,
    REG_MAX_ANG    = 3'd3,
    REG_WHEELBASE  = 3'd4,
    REG_HALF_TRACK = 3'd5,
    REG_INVERT     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [VEL_W-1:0] lin;
    logic [LM_W-1:0]         lm1000;
    logic                    neg;
    logic                    ang_en;
  } jav_side_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] lin;
    logic                    neg;
    logic                    ang_en;
    logic                    den_zero;
  } jav_dside_t;

endpackage

`default_nettype wire

### hw/rtl/jav_cordic.sv
// ----------------------------------------------------------------------------
// jav_cordic
// Rotation-mode CORDIC, one iteration per register stage; returns the
// gain-scaled cosine and sine of the Q30 angle.
// ----------------------------------------------------------------------------
`default_nettype none

module jav_cordic (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  input  wire logic signed [jav_pkg::CORDIC_W-1:0]    z_i,
  input  wire jav_pkg::jav_side_t                     side_i,
  output logic                                        valid_o,
  output logic signed [jav_pkg::CORDIC_W-1:0]         cos_o,
  output logic signed [jav_pkg::CORDIC_W-1:0]         sin_o,
  output jav_pkg::jav_side_t                          side_o
);

  localparam int unsigned N = jav_pkg::CORDIC_ITERS;
  localparam int unsigned W = jav_pkg::CORDIC_W;

  logic [N-1:0]        v_q;
  logic signed [W-1:0] x_q [N];
  logic signed [W-1:0] y_q [N];
  logic signed [W-1:0] z_q [N-1];
  jav_pkg::jav_side_t  side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_it
    logic signed [W-1:0] x_in, y_in, z_in;
    jav_pkg::jav_side_t  s_in;
    logic                v_in;

    if (i == 0) begin : g_first
      assign x_in = 32'sh2000_0000;
      assign y_in = '0;
      assign z_in = z_i;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign s_in = side_q[i-1];
      assign v_in = v_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[i] <= s_in;
      if (z_in >= 0) begin
        x_q[i] <= x_in - (y_in >>> i);
        y_q[i] <= y_in + (x_in >>> i);
      end else begin
        x_q[i] <= x_in + (y_in >>> i);
        y_q[i] <= y_in - (x_in >>> i);
      end
    end

    if (i < N - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (z_in >= 0) begin
          z_q[i] <= z_in - $signed(jav_pkg::ATAN_TAB[i]);
        end else begin
          z_q[i] <= z_in + $signed(jav_pkg::ATAN_TAB[i]);
        end
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign cos_o   = x_q[N-1];
  assign sin_o   = y_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire

### hw/rtl/jav_div.sv
// ----------------------------------------------------------------------------
// jav_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module jav_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [jav_pkg::N_W-1:0]     n_i,
  input  wire logic [jav_pkg::D_W-1:0]     d_i,
  input  wire jav_pkg::jav_dside_t         side_i,
  output logic                             valid_o,
  output logic [jav_pkg::Q_W-1:0]          q_o,
  output logic                             over_o,
  output jav_pkg::jav_dside_t              side_o
);

  localparam int unsigned QW = jav_pkg::Q_W;
  localparam int unsigned NW = jav_pkg::N_W;
  localparam int unsigned DW = jav_pkg::D_W;
  localparam int unsigned CW = DW + QW + 1;

  logic [QW-1:0]       v_q;
  logic [NW-1:0]       r_q [QW-1];
  logic [DW-1:0]       d_q [QW-1];
  logic [QW-1:0]       q_q [QW];
  logic                over_q [QW];
  jav_pkg::jav_dside_t side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int unsigned B = QW - 1 - k;
    logic [NW-1:0]       r_in;
    logic [DW-1:0]       d_in;
    logic [QW-1:0]       q_in;
    logic                over_in;
    jav_pkg::jav_dside_t s_in;
    logic                v_in;
    logic [CW-1:0]       dsh;
    logic                ge;

    if (k == 0) begin : g_first
      assign r_in    = n_i;
      assign d_in    = d_i;
      assign q_in    = '0;
      assign over_in = CW'(n_i) >= (CW'(d_i) << QW);
      assign s_in    = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign r_in    = r_q[k-1];
      assign d_in    = d_q[k-1];
      assign q_in    = q_q[k-1];
      assign over_in = over_q[k-1];
      assign s_in    = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign dsh = CW'(d_in) << B;
    assign ge  = CW'(r_in) >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= s_in;
      over_q[k] <= over_in;
      q_q[k]    <= ge ? (q_in | (QW'(1) << B)) : q_in;
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        d_q[k] <= d_in;
        r_q[k] <= ge ? (r_in - dsh[NW-1:0]) : r_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign q_o     = q_q[QW-1];
  assign over_o  = over_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

### hw/rtl/joystick_to_arc_velocity_unit.sv
// ----------------------------------------------------------------------------
// joystick_to_arc_velocity_unit
// Turns joystick speed and steer axes into a forward velocity and a yaw
// rate for a car-steered vehicle.
//
// Channel   Direction  Handshake                Payload
// request   in         start, busy              speed_axis_i, steer_axis_i
// result    out        done_o (one cycle)       linear_velocity_o, angular_velocity_o
// config    in         cfg_valid_i, cfg_ready_o cfg_index_i, cfg_data_i
//
// One request per cycle; each result passes through stages A and B, the
// 28-stage CORDIC, stages D to F, the 17-stage quotient pipeline and G.
// busy and cfg_ready_o follow reset only. Reset clears all valid bits and
// loads the register defaults. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_to_arc_velocity_unit #(
  parameter int unsigned AXIS_WIDTH      = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 14
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [AXIS_WIDTH-1:0]          speed_axis_i,
  input  wire logic signed [AXIS_WIDTH-1:0]          steer_axis_i,
  output logic                                       done_o,
  output logic signed [jav_pkg::VEL_W-1:0]           linear_velocity_o,
  output logic signed [jav_pkg::VEL_W-1:0]           angular_velocity_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [jav_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [jav_pkg::CFG_DAT_W-1:0]         cfg_data_i
);

  localparam int unsigned AW    = AXIS_WIDTH;
  localparam int unsigned SH    = AW - 1;
  localparam int unsigned PW    = AW + 16;
  localparam int unsigned CMP_W = (AW > 15) ? AW : 15;
  localparam int unsigned ZSH   = 30 - ANGLE_FRAC_BITS;
  localparam int unsigned VW    = jav_pkg::VEL_W;
  localparam logic [31:0] ANG_LIM =
    32'((jav_pkg::HALF_PI_Q30 >>> ZSH) - 64'sd1);

  // configuration registers
  logic [14:0] speed_db_q, steer_db_q, max_lin_q, max_ang_q;
  logic [jav_pkg::GEOM_W-1:0] wheelbase_q, half_track_q;
  logic [1:0]  invert_q;

  assign busy        = !rst_ni;
  assign cfg_ready_o = rst_ni;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_db_q   <= 15'd1638;
      steer_db_q   <= 15'd1638;
      max_lin_q    <= 15'd500;
      max_ang_q    <= 15'd12867;
      wheelbase_q  <= 12'd285;
      half_track_q <= 12'd210;
      invert_q     <= 2'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (jav_pkg::reg_idx_e'(cfg_index_i))
        jav_pkg::REG_SPEED_DB:   speed_db_q   <= cfg_data_i;
        jav_pkg::REG_STEER_DB:   steer_db_q   <= cfg_data_i;
        jav_pkg::REG_MAX_LIN:    max_lin_q    <= cfg_data_i;
        jav_pkg::REG_MAX_ANG:    max_ang_q    <= cfg_data_i;
        jav_pkg::REG_WHEELBASE:  wheelbase_q  <= cfg_data_i[jav_pkg::GEOM_W-1:0];
        jav_pkg::REG_HALF_TRACK: half_track_q <= cfg_data_i[jav_pkg::GEOM_W-1:0];
        jav_pkg::REG_INVERT:     invert_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // stage A: magnitudes, deadbands, scaling products
  logic [AW-1:0]        sp_mag, st_mag;
  logic signed [PW-1:0] plin_d;
  logic [PW-1:0]        pang_d;
  logic                 v_a_q, sp_pass_a_q, st_pass_a_q, st_neg_a_q;
  logic signed [PW-1:0] plin_a_q;
  logic [PW-1:0]        pang_a_q;

  assign sp_mag = speed_axis_i[AW-1] ? (~speed_axis_i + 1'b1) : speed_axis_i;
  assign st_mag = steer_axis_i[AW-1] ? (~steer_axis_i + 1'b1) : steer_axis_i;
  assign plin_d = speed_axis_i * $signed({1'b0, max_lin_q});
  assign pang_d = PW'(st_mag) * PW'(max_ang_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
    end else begin
      v_a_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    plin_a_q    <= plin_d;
    pang_a_q    <= pang_d;
    sp_pass_a_q <= CMP_W'(sp_mag) > CMP_W'(speed_db_q);
    st_pass_a_q <= CMP_W'(st_mag) > CMP_W'(steer_db_q);
    st_neg_a_q  <= steer_axis_i[AW-1];
  end

  // stage B: linear velocity and steering angle
  logic signed [PW-1:0] plin_sh;
  logic signed [VW-1:0] lin_raw, lin_d;
  logic [PW-1:0]        pang_rnd;
  logic [31:0]          amag32, amag_cl;
  logic                 v_b_q, aneg_b_q, ang_en_b_q;
  logic signed [VW-1:0] lin_b_q;
  logic signed [31:0]   z_b_q;

  assign plin_sh  = plin_a_q >>> SH;
  assign lin_raw  = plin_sh[VW-1:0];
  assign lin_d    = !sp_pass_a_q ? '0 : (invert_q[0] ? -lin_raw : lin_raw);
  assign pang_rnd = pang_a_q + (PW'(1) << (SH - 1));
  assign amag32   = 32'(pang_rnd[SH +: 15]);
  assign amag_cl  = (amag32 > ANG_LIM) ? ANG_LIM : amag32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_b_q <= 1'b0;
    end else begin
      v_b_q <= v_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lin_b_q    <= lin_d;
    z_b_q      <= $signed(amag_cl << ZSH);
    aneg_b_q   <= st_neg_a_q ^ invert_q[1];
    ang_en_b_q <= st_pass_a_q && (amag_cl != '0);
  end

  // CORDIC
  logic [VW-1:0]      lin_neg;
  logic [14:0]        lmag;
  jav_pkg::jav_side_t side_c;
  logic               v_cr;
  logic signed [31:0] cos_cr, sin_cr;
  jav_pkg::jav_side_t side_cr;

  assign lin_neg        = -lin_b_q;
  assign lmag           = lin_b_q[VW-1] ? lin_neg[14:0] : lin_b_q[14:0];
  assign side_c.lin     = lin_b_q;
  assign side_c.lm1000  = jav_pkg::LM_W'(lmag) * jav_pkg::LM_W'(1000);
  assign side_c.neg     = lin_b_q[VW-1] ^ aneg_b_q;
  assign side_c.ang_en  = ang_en_b_q;

  jav_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_b_q),
    .z_i     (z_b_q),
    .side_i  (side_c),
    .valid_o (v_cr),
    .cos_o   (cos_cr),
    .sin_o   (sin_cr),
    .side_o  (side_cr)
  );

  // stage D: numerator and denominator products
  logic [jav_pkg::SC_W-1:0]  s_cl, c_cl;
  logic                      v_d_q;
  logic [jav_pkg::NUM_W-1:0] num_d_q;
  logic [jav_pkg::PRD_W-1:0] wc_d_q, hs_d_q;
  jav_pkg::jav_dside_t       side_d_q;

  assign s_cl = (sin_cr < 1) ? jav_pkg::SC_W'(1) : sin_cr[jav_pkg::SC_W-1:0];
  assign c_cl = (cos_cr < 0) ? '0 : cos_cr[jav_pkg::SC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_d_q <= 1'b0;
    end else begin
      v_d_q <= v_cr;
    end
  end

  always_ff @(posedge clk_i) begin
    num_d_q           <= jav_pkg::NUM_W'(side_cr.lm1000) * jav_pkg::NUM_W'(s_cl);
    wc_d_q            <= jav_pkg::PRD_W'(wheelbase_q) * jav_pkg::PRD_W'(c_cl);
    hs_d_q            <= jav_pkg::PRD_W'(half_track_q) * jav_pkg::PRD_W'(s_cl);
    side_d_q.lin      <= side_cr.lin;
    side_d_q.neg      <= side_cr.neg;
    side_d_q.ang_en   <= side_cr.ang_en;
    side_d_q.den_zero <= 1'b0;
  end

  // stage E: turn centre denominator
  logic                      v_e_q;
  logic [jav_pkg::NUM_W-1:0] num_e_q;
  logic [jav_pkg::DEN_W-1:0] den_e_q;
  jav_pkg::jav_dside_t       side_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_e_q <= 1'b0;
    end else begin
      v_e_q <= v_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_e_q  <= num_d_q;
    den_e_q  <= jav_pkg::DEN_W'(wc_d_q) + jav_pkg::DEN_W'(hs_d_q);
    side_e_q <= side_d_q;
  end

  // stage F: rounded dividend and divisor
  logic                    v_f_q;
  logic [jav_pkg::N_W-1:0] n_f_q;
  logic [jav_pkg::D_W-1:0] d_f_q;
  jav_pkg::jav_dside_t     side_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f_q <= 1'b0;
    end else begin
      v_f_q <= v_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_f_q             <= {num_e_q, 1'b0} + jav_pkg::N_W'(den_e_q);
    d_f_q             <= {den_e_q, 1'b0};
    side_f_q.lin      <= side_e_q.lin;
    side_f_q.neg      <= side_e_q.neg;
    side_f_q.ang_en   <= side_e_q.ang_en;
    side_f_q.den_zero <= den_e_q == '0;
  end

  logic                    v_dv, over_dv;
  logic [jav_pkg::Q_W-1:0] q_dv;
  jav_pkg::jav_dside_t     side_dv;

  jav_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_f_q),
    .n_i     (n_f_q),
    .d_i     (d_f_q),
    .side_i  (side_f_q),
    .valid_o (v_dv),
    .q_o     (q_dv),
    .over_o  (over_dv),
    .side_o  (side_dv)
  );

  // stage G: sign, saturation, output register
  logic [17:0]          magv;
  logic signed [VW-1:0] ang_d;
  logic                 done_q;
  logic signed [VW-1:0] lin_o_q, ang_o_q;

  always_comb begin
    if (side_dv.den_zero) begin
      magv = (side_dv.lin != '0) ? 18'd32768 : 18'd0;
    end else if (over_dv) begin
      magv = 18'h20000;
    end else begin
      magv = {1'b0, q_dv};
    end
    if (!side_dv.ang_en) begin
      ang_d = '0;
    end else if (side_dv.neg) begin
      ang_d = (magv > 18'd32768) ? 16'sh8000 : -$signed(magv[VW-1:0]);
    end else begin
      ang_d = (magv > 18'd32767) ? 16'sh7FFF : $signed(magv[VW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_dv;
    end
  end

  always_ff @(posedge clk_i) begin
    lin_o_q <= side_dv.lin;
    ang_o_q <= ang_d;
  end

  assign done_o             = done_q;
  assign linear_velocity_o  = lin_o_q;
  assign angular_velocity_o = ang_o_q;

endmodule

`default_nettype wire

### hw/rtl/jav_checker.sv
// ----------------------------------------------------------------------------
// jav_checker
// Port-level checks for the joystick to arc velocity unit.
// ----------------------------------------------------------------------------
`default_nettype none

module jav_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              busy,
  input wire logic                              cfg_ready_o,
  input wire logic                              done_o,
  input wire logic signed [jav_pkg::VEL_W-1:0]  linear_velocity_o,
  input wire logic signed [jav_pkg::VEL_W-1:0]  angular_velocity_o
);

  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !done_o)
    else $error("result strobe right after reset");

  a_ready_out_of_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o)
    else $error("request or config port blocked out of reset");

  a_yaw_needs_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (angular_velocity_o != 16'sd0) |-> linear_velocity_o != 16'sd0)
    else $error("yaw rate without forward speed");

  a_linear_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> linear_velocity_o != 16'sh8000)
    else $error("linear velocity out of range");

endmodule

bind joystick_to_arc_velocity_unit jav_checker u_jav_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .busy               (busy),
  .cfg_ready_o        (cfg_ready_o),
  .done_o             (done_o),
  .linear_velocity_o  (linear_velocity_o),
  .angular_velocity_o (angular_velocity_o)
);

`default_nettype wire
